// File: rtl/core/smmu_pkg.sv
// Shared codes, field widths and constants for the segmented MMU translator.
package smmu_pkg;

  localparam int unsigned VA_W    = 16;
  localparam int unsigned PA_W    = 23;
  localparam int unsigned WORD_W  = 16;
  localparam int unsigned PAGES   = 8;
  localparam int unsigned SPACES  = 2;
  localparam int unsigned ENTRIES = PAGES * SPACES;
  localparam int unsigned PAGE_W  = $clog2(PAGES);
  localparam int unsigned ADDR_W  = $clog2(ENTRIES);
  localparam int unsigned IN_W    = 48;
  localparam int unsigned OUT_W   = 40;

  typedef enum logic [1:0] {
    OP_TRANSLATE = 2'd0,
    OP_WRITE_PAR = 2'd1,
    OP_WRITE_PDR = 2'd2,
    OP_WRITE_SR  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_ABORT  = 2'd1,
    ST_NOIMPL = 2'd2,
    ST_UNUSED = 2'd3
  } res_status_t;

  typedef enum logic [1:0] {
    SEL_CURRENT  = 2'd0,
    SEL_PREVIOUS = 2'd1,
    SEL_KERNEL   = 2'd2,
    SEL_INVALID  = 2'd3
  } map_sel_t;

  localparam logic [1:0] MODE_KERNEL = 2'd0;
  localparam logic [1:0] MODE_SUPER  = 2'd1;
  localparam logic [1:0] MODE_USER   = 2'd3;

  localparam logic [PA_W-1:0]   IO_PAGE_BASE  = 23'o0760000;
  localparam logic [VA_W-1:0]   IO_PAGE_START = 16'o160000;
  localparam logic [WORD_W-1:0] ABORT_NONRES  = 16'o100000;
  localparam logic [WORD_W-1:0] ABORT_LENGTH  = 16'o040000;
  localparam logic [WORD_W-1:0] ABORT_RDONLY  = 16'o020000;
  localparam logic [WORD_W-1:0] WRITTEN_BIT   = 16'o000100;
  localparam logic [WORD_W-1:0] USER_MODE_BITS = 16'o000140;

endpackage

// File: rtl/core/segmented_mmu_translate_top.sv
// Segmented MMU: page register memories, address translation and abort status.
// Timing: the input beat is registered in stage 1 and the result beat in the output register.
// Throughput: one beat per cycle unless the output stalls; page registers sit in two
// registered-read RAMs, a pending write-back is forwarded to the item read in the same cycle.
// Reset: synchronous, clears the status register and all page entry valid bits,
// so every page register reads zero until written.
module segmented_mmu_translate_top (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_tvalid,
  output logic                        s_tready,
  // [15:0] virtual_address, [19:16] mode_bits, [21:20] mapping_select, [22] is_write,
  // [23] reg_space, [26:24] reg_index, [42:27] write_data, [47:43] zero
  input  logic [smmu_pkg::IN_W-1:0]   s_tdata,
  // [1:0] operation
  input  logic [1:0]                  s_tuser,
  output logic                        m_tvalid,
  input  logic                        m_tready,
  // [22:0] physical_address, [38:23] status_word, [39] zero
  output logic [smmu_pkg::OUT_W-1:0]  m_tdata,
  // [1:0] status
  output logic [1:0]                  m_tuser
);
  import smmu_pkg::*;

  // input unpack
  logic [VA_W-1:0]   in_va;
  logic [3:0]        in_modes;
  logic [1:0]        in_sel;
  logic              in_wr;
  logic              in_space;
  logic [PAGE_W-1:0] in_ri;
  logic [WORD_W-1:0] in_data;
  logic [1:0]        in_mode;
  logic [ADDR_W-1:0] in_addr;

  assign in_va    = s_tdata[15:0];
  assign in_modes = s_tdata[19:16];
  assign in_sel   = s_tdata[21:20];
  assign in_wr    = s_tdata[22];
  assign in_space = s_tdata[23];
  assign in_ri    = s_tdata[26:24];
  assign in_data  = s_tdata[42:27];

  always_comb begin
    case (map_sel_t'(in_sel))
      SEL_CURRENT:  in_mode = in_modes[3:2];
      SEL_PREVIOUS: in_mode = in_modes[1:0];
      SEL_KERNEL:   in_mode = MODE_KERNEL;
      default:      in_mode = MODE_SUPER;
    endcase
    if (op_t'(s_tuser) == OP_TRANSLATE) begin
      in_addr = {in_mode == MODE_USER, in_va[VA_W-1 -: PAGE_W]};
    end else begin
      in_addr = {in_space, in_ri};
    end
  end

  // stage 1 registers
  logic              s1_valid;
  op_t               s1_op;
  logic [VA_W-1:0]   s1_va;
  logic [1:0]        s1_mode;
  logic              s1_wr;
  logic [ADDR_W-1:0] s1_addr;
  logic [WORD_W-1:0] s1_data;

  logic advance;
  logic take;
  assign advance  = !m_tvalid || m_tready;
  assign s_tready = !s1_valid || advance;
  assign take     = s_tvalid && s_tready;

  // page register memories
  logic [WORD_W-1:0]  par_mem [ENTRIES];
  logic [WORD_W-1:0]  pdr_mem [ENTRIES];
  logic [ENTRIES-1:0] par_vld;
  logic [ENTRIES-1:0] pdr_vld;
  logic [WORD_W-1:0]  par_q;
  logic [WORD_W-1:0]  pdr_q;
  logic               par_vq;
  logic               pdr_vq;
  logic [ADDR_W-1:0]  rd_addr;

  logic              par_we;
  logic              pdr_we;
  logic [WORD_W-1:0] par_wdata;
  logic [WORD_W-1:0] pdr_wdata;

  // last cycle's write-back, for the item whose read overlapped it
  logic              fw_par;
  logic              fw_pdr;
  logic [ADDR_W-1:0] fw_addr;
  logic [WORD_W-1:0] fw_par_data;
  logic [WORD_W-1:0] fw_pdr_data;

  assign rd_addr = take ? in_addr : s1_addr;

  always_ff @(posedge clk) begin
    par_q  <= par_mem[rd_addr];
    pdr_q  <= pdr_mem[rd_addr];
    par_vq <= par_vld[rd_addr];
    pdr_vq <= pdr_vld[rd_addr];
    if (par_we) begin
      par_mem[s1_addr] <= par_wdata;
    end
    if (pdr_we) begin
      pdr_mem[s1_addr] <= pdr_wdata;
    end
    fw_addr     <= s1_addr;
    fw_par_data <= par_wdata;
    fw_pdr_data <= pdr_wdata;
  end

  // stage 1 evaluation
  logic [WORD_W-1:0] mmu_status;
  logic [WORD_W-1:0] mmu_status_next;
  logic [WORD_W-1:0] par;
  logic [WORD_W-1:0] desc;
  logic [PAGE_W-1:0] page;
  logic [6:0]        blk;
  logic [6:0]        plf;
  logic              user;
  logic              len_fault;
  logic [WORD_W-1:0] cause;
  logic [1:0]        res_st;
  logic [PA_W-1:0]   res_pa;
  logic              fire;

  assign fire = s1_valid && advance;
  assign par  = (fw_par && fw_addr == s1_addr) ? fw_par_data : (par_vq ? par_q : '0);
  assign desc = (fw_pdr && fw_addr == s1_addr) ? fw_pdr_data : (pdr_vq ? pdr_q : '0);
  assign page = s1_va[VA_W-1 -: PAGE_W];
  assign blk  = s1_va[12:6];
  assign plf  = desc[14:8];
  assign user = (s1_mode == MODE_USER);
  assign len_fault = desc[3] ? (blk < plf) : (blk > plf);

  always_comb begin
    mmu_status_next = mmu_status;
    res_st    = ST_OK;
    res_pa    = '0;
    par_we    = 1'b0;
    pdr_we    = 1'b0;
    par_wdata = s1_data;
    pdr_wdata = s1_data;
    cause     = '0;
    case (s1_op)
      OP_WRITE_PAR: par_we = fire;
      OP_WRITE_PDR: pdr_we = fire;
      OP_WRITE_SR:  mmu_status_next = s1_data;
      OP_TRANSLATE: begin
        if (!mmu_status[0]) begin
          if (s1_va >= IO_PAGE_START) begin
            res_pa = IO_PAGE_BASE + {{(PA_W-13){1'b0}}, s1_va[12:0]};
          end else begin
            res_pa = {{(PA_W-VA_W){1'b0}}, s1_va};
          end
        end else if (s1_mode != MODE_KERNEL && s1_mode != MODE_USER) begin
          res_st = ST_NOIMPL;
        end else begin
          if (!desc[1]) begin
            cause = ABORT_NONRES;
          end else if (len_fault) begin
            cause = ABORT_LENGTH;
          end else if (s1_wr && !desc[2]) begin
            cause = ABORT_RDONLY;
          end
          if (cause != '0) begin
            res_st = ST_ABORT;
            mmu_status_next = mmu_status | cause | (user ? USER_MODE_BITS : '0)
                            | {{(WORD_W-PAGE_W-1){1'b0}}, page, 1'b0};
          end else begin
            res_pa    = {1'b0, par, 6'b0} + {{(PA_W-13){1'b0}}, s1_va[12:0]};
            pdr_we    = fire && s1_wr;
            pdr_wdata = desc | WRITTEN_BIT;
          end
        end
      end
      default: res_st = ST_OK;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid   <= 1'b0;
      m_tvalid   <= 1'b0;
      mmu_status <= '0;
      par_vld    <= '0;
      pdr_vld    <= '0;
      fw_par     <= 1'b0;
      fw_pdr     <= 1'b0;
    end else begin
      fw_par <= par_we;
      fw_pdr <= pdr_we;
      if (par_we) begin
        par_vld[s1_addr] <= 1'b1;
      end
      if (pdr_we) begin
        pdr_vld[s1_addr] <= 1'b1;
      end
      if (take) begin
        s1_valid <= 1'b1;
      end else if (fire) begin
        s1_valid <= 1'b0;
      end
      if (fire) begin
        mmu_status <= mmu_status_next;
        m_tvalid   <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      s1_op   <= op_t'(s_tuser);
      s1_va   <= in_va;
      s1_mode <= (in_sel == SEL_INVALID) ? MODE_SUPER : in_mode;
      s1_wr   <= in_wr;
      s1_addr <= in_addr;
      s1_data <= in_data;
    end
    if (fire) begin
      m_tuser <= res_st;
      m_tdata <= {1'b0, mmu_status_next, res_pa};
    end
  end

`ifndef SYNTHESIS
  a_abort_sets_cause: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == ST_ABORT |-> (m_tdata[38] || m_tdata[37] || m_tdata[36]))
    else $error("abort result without a cause bit in the status word");

  a_fault_no_address: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser != ST_OK |-> m_tdata[22:0] == '0)
    else $error("faulted result carries a physical address");

  a_reset_unmapped: assert property (@(posedge clk)
    $past(rst) |-> mmu_status == '0 && par_vld == '0 && pdr_vld == '0)
    else $error("reset left mapping state behind");
`endif

endmodule
